// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== rtl/abst_pkg.sv =====
// types and constants of the array binary search tree
// no dependencies; used by the datapath, the controller and the top level
package abst_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    // next walk position
    typedef enum logic [2:0] {
        POS_HOLD,
        POS_ROOT,
        POS_DESCEND,
        POS_LEFT_POS,
        POS_RIGHT_POS,
        POS_STEP_POS,
        POS_RIGHT_CUR,
        POS_LEFT_SRC
    } pos_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_POS,
        CUR_SRC
    } cur_sel_t;

    typedef enum logic [1:0] {
        WA_POS,
        WA_CUR,
        WA_CLR
    } wr_addr_sel_t;

    typedef enum logic [1:0] {
        WD_KEY,
        WD_SRC,
        WD_ZERO
    } wr_data_sel_t;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_POS,
        SLOT_HIT
    } slot_sel_t;

    typedef struct packed {
        logic         latch_in;
        pos_sel_t     pos_sel;
        cur_sel_t     cur_sel;
        logic         hit_load;
        logic         src_load;
        logic         step_load;
        logic         step_right;
        logic         rd_en;
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        logic         res_load;
        status_t      res_status;
        slot_sel_t    res_slot_sel;
        logic         out_load;
        logic         clr_step;
    } cmd_t;

    typedef struct packed {
        logic key_bad;
        logic is_insert;
        logic is_find;
        logic pos_in_range;
        logic rd_zero;
        logic rd_eq;
        logic clr_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/array_binary_search_tree.sv =====
// top level of the array binary search tree
// depends on abst_pkg, abst_ctrl and abst_datapath
//
// usage:
//   input channel (s_valid/s_ready, s_kind, s_key_value): one word per operation,
//     kind insert, delete or find of a nonzero value
//   result channel (m_valid/m_ready, m_status, m_slot): one word per input word,
//     status done, not found, no room or invalid word, and the slot touched
//   the tree sits in a node store of 2^TREE_LEVELS - 1 slots, root at 0, children
//     of slot i at 2i+1 and 2i+2, a zero value marks an empty slot
//   one operation at a time, s_ready rises in the same cycle as m_valid;
//     every store read is registered, a read state then a check state per slot visited
//   a rejected word goes straight to the result; an insert or find walks down
//     from the root (depth 0) to the slot where it stops; a delete then checks the
//     children of each slot it refills, walks the replacement path and moves
//     the replacement value up into that slot
//   reset: the store is cleared by a sweep over all 2^TREE_LEVELS - 1 slots,
//     with s_ready low until it finishes
//   a stalled result waits in the output register; the next word is taken as
//     soon as the block is idle, and its result waits until the old one leaves

module array_binary_search_tree
    import abst_pkg::*;
#(
    parameter int TREE_LEVELS = 7,
    parameter int VALUE_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // operation words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [KEY_W-1:0]    s_key_value,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot
);

    // commands toward the datapath, status back to the controller
    cmd_t  cmd;
    stat_t st;

    abst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // store, walk registers and the output register
    abst_datapath #(
        .TREE_LEVELS (TREE_LEVELS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_kind      (s_kind),
        .s_key_value (s_key_value),
        .cmd         (cmd),
        .st          (st),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_status    (m_status),
        .m_slot      (m_slot)
    );

endmodule

// ===== rtl/abst_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module abst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 127,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/abst_datapath.sv =====
// datapath: node store, walk registers, result and output registers
// depends on abst_pkg, abst_ram and assert_macros.svh
`include "assert_macros.svh"

module abst_datapath
    import abst_pkg::*;
#(
    parameter int TREE_LEVELS = 7,
    parameter int VALUE_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [KEY_W-1:0]    s_key_value,
    input  cmd_t                cmd,
    output stat_t               st,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_slot
);

    localparam int ADDR_W = TREE_LEVELS;
    localparam int POS_W  = TREE_LEVELS + 1;
    localparam int SLOTS  = (1 << TREE_LEVELS) - 1;

    localparam logic [POS_W-1:0]  SLOTS_POS = POS_W'(SLOTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

    logic [KIND_W-1:0]     kind_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [ADDR_W-1:0]     cur_reg, hit_reg, src_reg;
    logic [VALUE_BITS-1:0] srcval_reg;
    logic                  step_right_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    status_t               res_status_reg;
    logic [ADDR_W-1:0]     res_slot_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SLOT_W-1:0]     m_slot_reg;

    logic [ADDR_W-1:0]     pos_lo;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [VALUE_BITS-1:0] rd_data;
    logic [ADDR_W-1:0]     res_slot;

    function automatic logic [POS_W-1:0] child(input logic [ADDR_W-1:0] p, input logic right);
        child = {p, 1'b0} + (right ? POS_W'(2) : POS_W'(1));
    endfunction

    assign pos_lo = pos_reg[ADDR_W-1:0];

    // status toward the controller
    always_comb begin
        st.key_bad = !(s_kind inside {KIND_INSERT, KIND_DELETE, KIND_FIND})
                     || (s_key_value == '0)
                     || ((32'(s_key_value) >> VALUE_BITS) != 32'd0);
        st.is_insert    = (kind_reg == KIND_INSERT);
        st.is_find      = (kind_reg == KIND_FIND);
        st.pos_in_range = (pos_reg < SLOTS_POS);
        st.rd_zero      = (rd_data == '0);
        st.rd_eq        = (rd_data == val_reg);
        st.clr_last     = (clr_cnt_reg == LAST_ADDR);
        st.out_free     = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (cmd.pos_sel)
            POS_ROOT:      pos_next = '0;
            POS_DESCEND:   pos_next = child(pos_lo, !(val_reg < rd_data));
            POS_LEFT_POS:  pos_next = child(pos_lo, 1'b0);
            POS_RIGHT_POS: pos_next = child(pos_lo, 1'b1);
            POS_STEP_POS:  pos_next = child(pos_lo, step_right_reg);
            POS_RIGHT_CUR: pos_next = child(cur_reg, 1'b1);
            POS_LEFT_SRC:  pos_next = child(src_reg, 1'b0);
            default:       pos_next = pos_reg;
        endcase
    end

    always_comb begin
        case (cmd.wr_addr_sel)
            WA_POS:  wr_addr = pos_lo;
            WA_CUR:  wr_addr = cur_reg;
            WA_CLR:  wr_addr = clr_cnt_reg;
            default: wr_addr = pos_lo;
        endcase
        case (cmd.wr_data_sel)
            WD_KEY:  wr_data = val_reg;
            WD_SRC:  wr_data = srcval_reg;
            WD_ZERO: wr_data = '0;
            default: wr_data = '0;
        endcase
        case (cmd.res_slot_sel)
            SLOT_POS: res_slot = pos_lo;
            SLOT_HIT: res_slot = hit_reg;
            default:  res_slot = '0;
        endcase
    end

    abst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (pos_lo),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            kind_reg <= s_kind;
            val_reg  <= VALUE_BITS'(s_key_value);
        end
        pos_reg <= pos_next;
        case (cmd.cur_sel)
            CUR_POS: cur_reg <= pos_lo;
            CUR_SRC: cur_reg <= src_reg;
            default: cur_reg <= cur_reg;
        endcase
        if (cmd.hit_load) begin
            hit_reg <= pos_lo;
        end
        if (cmd.src_load) begin
            src_reg    <= pos_lo;
            srcval_reg <= rd_data;
        end
        if (cmd.step_load) begin
            step_right_reg <= cmd.step_right;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= res_slot;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= SLOT_W'(res_slot_reg);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

    `ASSERT_NEXT(a_out_load_valid, aclk, aresetn, cmd.out_load, m_valid_reg)
    `ASSERT_IMPLY(a_fail_slot_zero, aclk, aresetn, m_valid_reg && m_status_reg != ST_DONE, m_slot_reg == '0)

endmodule

// ===== rtl/abst_ctrl.sv =====
// controller: sequences store clearing, tree walks and node removal
// depends on abst_pkg and assert_macros.svh
`include "assert_macros.svh"

module abst_ctrl
    import abst_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_CLEAR    = 12'b0000_0000_0010,
        S_WALK_RD  = 12'b0000_0000_0100,
        S_WALK_CHK = 12'b0000_0000_1000,
        S_RM_LRD   = 12'b0000_0001_0000,
        S_RM_LCHK  = 12'b0000_0010_0000,
        S_RM_RRD   = 12'b0000_0100_0000,
        S_RM_RCHK  = 12'b0000_1000_0000,
        S_EXT_RD   = 12'b0001_0000_0000,
        S_EXT_CHK  = 12'b0010_0000_0000,
        S_MOVE     = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.pos_sel  = POS_HOLD;
        cmd.cur_sel  = CUR_HOLD;
        cmd.wr_addr_sel  = WA_POS;
        cmd.wr_data_sel  = WD_KEY;
        cmd.res_status   = ST_DONE;
        cmd.res_slot_sel = SLOT_ZERO;
        s_ready      = 1'b0;
        state_next   = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step    = 1'b1;
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_CLR;
                cmd.wr_data_sel = WD_ZERO;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    if (st.key_bad) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_INVALID;
                        state_next     = S_EMIT;
                    end else begin
                        cmd.pos_sel = POS_ROOT;
                        state_next  = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                if (st.pos_in_range) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WALK_CHK;
                end else begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = st.is_insert ? ST_NO_ROOM : ST_NOT_FOUND;
                    state_next     = S_EMIT;
                end
            end
            S_WALK_CHK: begin
                if (st.rd_zero) begin
                    cmd.res_load = 1'b1;
                    if (st.is_insert) begin
                        cmd.wr_en        = 1'b1;
                        cmd.res_slot_sel = SLOT_POS;
                    end else begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    state_next = S_EMIT;
                end else if (!st.is_insert && st.rd_eq) begin
                    cmd.hit_load = 1'b1;
                    cmd.cur_sel  = CUR_POS;
                    if (st.is_find) begin
                        cmd.res_load     = 1'b1;
                        cmd.res_slot_sel = SLOT_POS;
                        state_next       = S_EMIT;
                    end else begin
                        cmd.pos_sel = POS_LEFT_POS;
                        state_next  = S_RM_LRD;
                    end
                end else begin
                    cmd.pos_sel = POS_DESCEND;
                    state_next  = S_WALK_RD;
                end
            end
            S_RM_LRD: begin
                if (st.pos_in_range) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_RM_LCHK;
                end else begin
                    cmd.pos_sel = POS_RIGHT_CUR;
                    state_next  = S_RM_RRD;
                end
            end
            S_RM_LCHK: begin
                if (!st.rd_zero) begin
                    cmd.src_load   = 1'b1;
                    cmd.step_load  = 1'b1;
                    cmd.step_right = 1'b1;
                    cmd.pos_sel    = POS_RIGHT_POS;
                    state_next     = S_EXT_RD;
                end else begin
                    cmd.pos_sel = POS_RIGHT_CUR;
                    state_next  = S_RM_RRD;
                end
            end
            S_RM_RRD: begin
                if (st.pos_in_range) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_RM_RCHK;
                end else begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_addr_sel  = WA_CUR;
                    cmd.wr_data_sel  = WD_ZERO;
                    cmd.res_load     = 1'b1;
                    cmd.res_slot_sel = SLOT_HIT;
                    state_next       = S_EMIT;
                end
            end
            S_RM_RCHK: begin
                if (!st.rd_zero) begin
                    cmd.src_load   = 1'b1;
                    cmd.step_load  = 1'b1;
                    cmd.step_right = 1'b0;
                    cmd.pos_sel    = POS_LEFT_POS;
                    state_next     = S_EXT_RD;
                end else begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_addr_sel  = WA_CUR;
                    cmd.wr_data_sel  = WD_ZERO;
                    cmd.res_load     = 1'b1;
                    cmd.res_slot_sel = SLOT_HIT;
                    state_next       = S_EMIT;
                end
            end
            S_EXT_RD: begin
                if (st.pos_in_range) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXT_CHK;
                end else begin
                    state_next = S_MOVE;
                end
            end
            S_EXT_CHK: begin
                if (!st.rd_zero) begin
                    cmd.src_load = 1'b1;
                    cmd.pos_sel  = POS_STEP_POS;
                    state_next   = S_EXT_RD;
                end else begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_addr_sel = WA_CUR;
                cmd.wr_data_sel = WD_SRC;
                cmd.cur_sel     = CUR_SRC;
                cmd.pos_sel     = POS_LEFT_SRC;
                state_next      = S_RM_LRD;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLY(a_read_in_range, aclk, aresetn, cmd.rd_en, st.pos_in_range)
    `ASSERT_NEXT(a_one_word_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the array binary search tree: directed table, then random words
// depends on abst_pkg and array_binary_search_tree; keeps its own copy of the node store
module tb
    import abst_pkg::*;
();

    localparam int TREE_LEVELS     = 7;
    localparam int SLOTS           = (1 << TREE_LEVELS) - 1;
    localparam int RANDOM_WORDS    = 1150;
    localparam int CALM_WORDS      = 150;     // tail of the run with no idling on either side
    localparam int HOLD_OFF_AT     = 300;     // words sent before the long result stall
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 100;     // well past the slowest delete
    localparam int CYCLE_LIMIT     = 600000;

    // kind code that the block must reject
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
    } tree_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        logic                typed;    // result below is checked as written
        tree_result_t        res;
    } op_row_t;

    // directed words, walked in order from an empty store
    // rows not typed are checked against the tree predictor
    localparam int DIRECTED_ROWS = 25;
    localparam op_row_t DIRECTED [DIRECTED_ROWS] = '{
        // zero value on every kind, then the unknown kind
        '{KIND_INSERT, 16'h0000, 1'b1, '{ST_INVALID,   7'd0}},
        '{KIND_DELETE, 16'h0000, 1'b1, '{ST_INVALID,   7'd0}},
        '{KIND_FIND,   16'h0000, 1'b1, '{ST_INVALID,   7'd0}},
        '{KIND_BAD,    16'h1234, 1'b1, '{ST_INVALID,   7'd0}},
        '{KIND_BAD,    16'hFFFF, 1'b1, '{ST_INVALID,   7'd0}},
        // empty store: nothing to find or delete
        '{KIND_FIND,   16'h8000, 1'b1, '{ST_NOT_FOUND, 7'd0}},
        '{KIND_DELETE, 16'h8000, 1'b1, '{ST_NOT_FOUND, 7'd0}},
        // root, then its two children at the value extremes
        '{KIND_INSERT, 16'h8000, 1'b1, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'h0001, 1'b1, '{ST_DONE,      7'd1}},
        '{KIND_INSERT, 16'hFFFF, 1'b1, '{ST_DONE,      7'd2}},
        // equal values chain down the right edge to the last slot
        '{KIND_INSERT, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        // path runs off the store
        '{KIND_INSERT, 16'hFFFF, 1'b1, '{ST_NO_ROOM,   7'd0}},
        '{KIND_INSERT, 16'h8000, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_FIND,   16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_FIND,   16'h0001, 1'b0, '{ST_DONE,      7'd0}},
        // root with a left child, then a node with a left subtree, then right-only root
        '{KIND_DELETE, 16'h8000, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_DELETE, 16'hFFFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_DELETE, 16'h0001, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_FIND,   16'h7FFF, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_INSERT, 16'h5555, 1'b0, '{ST_DONE,      7'd0}},
        '{KIND_DELETE, 16'hAAAA, 1'b0, '{ST_DONE,      7'd0}}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind;
    logic [KEY_W-1:0]    s_key_value;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_slot;

    // predictor copy of the node store, updated when an operation word is accepted
    logic [KEY_W-1:0]    tree_slots [SLOTS];
    tree_result_t        awaited_results [$];

    // typed expectation of the word now on the input, set with its payload
    logic                row_typed;
    tree_result_t        row_result;

    int                  words_sent;
    bit                  calm;
    int                  errors;
    int                  cycle_count;

    array_binary_search_tree #(
        .TREE_LEVELS(TREE_LEVELS),
        .VALUE_BITS (KEY_W)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_key_value(s_key_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot     (m_slot)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // a child index past the store counts as empty
    function automatic bit occupied(input int p);
        return p < SLOTS && tree_slots[p] != '0;
    endfunction

    // applies one operation to the predictor store and returns its result word
    function automatic tree_result_t run_tree_op(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0]  key);
        tree_result_t r;
        int           p;
        int           src;
        bit           hit;
        r      = '{status: ST_DONE, slot: '0};
        p      = 0;
        hit    = 1'b0;
        if (kind == KIND_BAD || key == '0) begin
            r.status = ST_INVALID;
            return r;
        end
        if (kind == KIND_INSERT) begin
            // smaller goes left, equal or larger goes right
            while (occupied(p))
                p = (key < tree_slots[p]) ? 2 * p + 1 : 2 * p + 2;
            if (p >= SLOTS) begin
                r.status = ST_NO_ROOM;
            end else begin
                tree_slots[p] = key;
                r.slot        = p[SLOT_W-1:0];
            end
            return r;
        end
        while (occupied(p) && !hit) begin
            if (tree_slots[p] == key)
                hit = 1'b1;
            else
                p = (key < tree_slots[p]) ? 2 * p + 1 : 2 * p + 2;
        end
        if (!hit) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        r.slot = p[SLOT_W-1:0];
        if (kind == KIND_DELETE) begin
            // pull replacements up until a leaf is reached, then clear the leaf
            while (occupied(2 * p + 1) || occupied(2 * p + 2)) begin
                if (occupied(2 * p + 1)) begin
                    src = 2 * p + 1;
                    while (occupied(2 * src + 2))
                        src = 2 * src + 2;
                end else begin
                    src = 2 * p + 2;
                    while (occupied(2 * src + 1))
                        src = 2 * src + 1;
                end
                tree_slots[p] = tree_slots[src];
                p             = src;
            end
            tree_slots[p] = '0;
        end
        return r;
    endfunction

    // a value now in the store, so deletes and finds mostly hit
    function automatic logic [KEY_W-1:0] pick_stored();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            if (tree_slots[(start + i) % SLOTS] != '0)
                return tree_slots[(start + i) % SLOTS];
        end
        return KEY_W'($urandom_range(1, 65535));
    endfunction

    // offers one word at a falling edge and returns at the falling edge after acceptance
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                             input logic typed, input tree_result_t res);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_key_value <= key;
        row_typed   = typed;
        row_result  = res;
        do
            @(posedge aclk);
        while (!s_ready);
        words_sent++;
        @(negedge aclk);
    endtask

    // predict on every accepted operation word, check every accepted result word
    always @(posedge aclk) begin : scoreboard
        tree_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = run_tree_op(s_kind, s_key_value);
                if (row_typed)
                    want = row_result;
                awaited_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing outstanding: status %0d slot %0d",
                           m_status, m_slot);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status != want.status) begin
                        $error("status: expected %s, actual %0d", want.status.name(), m_status);
                        errors++;
                    end
                    if (m_slot != want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, m_slot);
                        errors++;
                    end
                end
            end
        end
    end

    // result side: short random stalls, one long hold-off to back the block up
    initial begin : receiver
        bit held_off;
        held_off = 1'b0;
        m_ready  = 1'b0;
        @(negedge aclk);
        forever begin
            if (!held_off && words_sent >= HOLD_OFF_AT) begin
                // sender keeps offering, so s_ready must drop while the output is stuck
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int                r;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_kind      = '0;
        s_key_value = '0;
        row_typed   = 1'b0;
        row_result  = '0;
        words_sent  = 0;
        calm        = 1'b0;
        errors      = 0;
        foreach (tree_slots[i])
            tree_slots[i] = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        // the store clearing sweep after reset is covered by the s_ready handshake
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].kind, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].res);

        // random part: mostly inserts, deletes and finds of live values, some noise
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= RANDOM_WORDS - CALM_WORDS);
            r    = $urandom_range(0, 99);
            if (r < 4) begin
                // rejected word: unknown kind with any value, or a zero value
                if ($urandom_range(0, 1) == 1) begin
                    kind = KIND_BAD;
                    key  = KEY_W'($urandom_range(0, 65535));
                end else begin
                    kind = KIND_W'($urandom_range(0, 2));
                    key  = '0;
                end
            end else if (r < 48) begin
                kind = KIND_INSERT;
                r    = $urandom_range(0, 9);
                if (r < 6)
                    key = KEY_W'($urandom_range(1, 65535));
                else if (r < 8)
                    key = KEY_W'($urandom_range(1, 40));    // crowded range, many equal values
                else
                    key = pick_stored();
            end else begin
                kind = (r < 73) ? KIND_DELETE : KIND_FIND;
                key  = ($urandom_range(0, 4) != 0) ? pick_stored()
                                                   : KEY_W'($urandom_range(1, 65535));
            end
            send_word(kind, key, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
